FILE: src/idf_pkg.sv
// Shared types, constants and helpers for the impact detect and frame block.
package idf_pkg;

   localparam int AXIS_W       = 16;
   localparam int TIME_W       = 32;
   localparam int CSR_DATA_W   = 32;
   localparam int CSR_INDEX_W  = 2;
   localparam int ID_W         = 8;
   localparam int CHECK_W      = 8;
   localparam int QUOT_W       = 12;   // |axis| / 10 <= 3276
   localparam int SQUARE_W     = 24;   // 3276^2 fits
   localparam int MAG_W        = 25;   // sum of three squares
   localparam int TOTAL_W      = 32;   // running total kept in full
   localparam int OUT_TOTAL_W  = 29;

   // divide by ten: (a * 52429) >> 19 is exact for every 16-bit a
   localparam int RECIP_W      = 17;
   localparam int PROD_W       = AXIS_W + RECIP_W;
   localparam logic [RECIP_W-1:0] RECIP_DIV10 = 17'd52429;
   localparam int DIV10_SHIFT  = 19;

   localparam logic [ID_W-1:0] FRAME_HEADER = 8'h69;

   localparam int WINDOW_LEN_DEFAULT = 10;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_DETECT_THRESHOLD = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_MIN_DATA_GAP     = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_HEARTBEAT_GAP    = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_NODE_ID          = 2'd3;

   localparam logic [TIME_W-1:0] MIN_DATA_GAP_RESET  = 32'd1000;
   localparam logic [TIME_W-1:0] HEARTBEAT_GAP_RESET = 32'd5000;

   typedef struct packed {
      logic [TOTAL_W-1:0] detect_threshold;
      logic [TIME_W-1:0]  min_data_gap_ms;
      logic [TIME_W-1:0]  heartbeat_gap_ms;
      logic [ID_W-1:0]    node_id;
   } csr_type;

   typedef struct packed {
      logic advance;
      logic valid;
   } pipe_ctrl_type;

   typedef struct packed {
      logic                   collision_send;
      logic                   heartbeat_send;
      logic [ID_W-1:0]        frame_id;
      logic [MAG_W-1:0]       frame_magnitude;
      logic [CHECK_W-1:0]     frame_check;
      logic [OUT_TOTAL_W-1:0] window_total;
   } result_type;

   function automatic logic [CHECK_W-1:0] frame_check_of(input logic [ID_W-1:0]  id,
                                                         input logic [MAG_W-1:0] mag);
      frame_check_of = FRAME_HEADER ^ id ^ mag[7:0] ^ mag[15:8] ^ mag[23:16]
                       ^ {7'd0, mag[24]};
   endfunction

endpackage

FILE: src/idf_if.sv
// Channel interfaces: sample request and detection response.
interface idf_req_if;
   import idf_pkg::*;
   logic                     valid;
   logic                     ready;
   logic signed [AXIS_W-1:0] accel_x;
   logic signed [AXIS_W-1:0] accel_y;
   logic signed [AXIS_W-1:0] accel_z;
   logic [TIME_W-1:0]        now_ms;

   modport source (output valid, accel_x, accel_y, accel_z, now_ms, input ready);
   modport sink   (input valid, accel_x, accel_y, accel_z, now_ms, output ready);
endinterface

interface idf_rsp_if;
   import idf_pkg::*;
   logic                   valid;
   logic                   ready;
   logic                   collision_send;
   logic                   heartbeat_send;
   logic [ID_W-1:0]        frame_id;
   logic [MAG_W-1:0]       frame_magnitude;
   logic [CHECK_W-1:0]     frame_check;
   logic [OUT_TOTAL_W-1:0] window_total;

   modport source (output valid, collision_send, heartbeat_send, frame_id,
                   frame_magnitude, frame_check, window_total, input ready);
   modport sink   (input valid, collision_send, heartbeat_send, frame_id,
                   frame_magnitude, frame_check, window_total, output ready);
endinterface

FILE: src/idf_lane.sv
// One axis lane: truncating divide by ten, then square (two stages).
module idf_lane (
   input  logic                              clock,
   input  logic                              advance,
   input  logic signed [idf_pkg::AXIS_W-1:0] accel,
   output logic [idf_pkg::SQUARE_W-1:0]      square
);
   import idf_pkg::*;

   logic [AXIS_W-1:0]   abs_val;
   logic [PROD_W-1:0]   prod_ff, prod_in;
   logic [QUOT_W-1:0]   quot;
   logic [SQUARE_W-1:0] square_ff, square_in;

   // sign drops out in the square, so work on the magnitude
   assign abs_val   = accel[AXIS_W-1] ? AXIS_W'(-accel) : AXIS_W'(accel);
   assign prod_in   = PROD_W'(abs_val) * PROD_W'(RECIP_DIV10);
   assign quot      = prod_ff[DIV10_SHIFT +: QUOT_W];
   assign square_in = SQUARE_W'(quot) * SQUARE_W'(quot);

   always_ff @(posedge clock) begin
      if (advance) begin
         prod_ff   <= prod_in;
         square_ff <= square_in;
      end
   end

   assign square = square_ff;
endmodule

FILE: src/idf_merge.sv
// Merge stage: sums the three lane squares into the sample magnitude.
module idf_merge (
   input  logic                          clock,
   input  logic                          advance,
   input  logic [idf_pkg::SQUARE_W-1:0]  square_x,
   input  logic [idf_pkg::SQUARE_W-1:0]  square_y,
   input  logic [idf_pkg::SQUARE_W-1:0]  square_z,
   output logic [idf_pkg::MAG_W-1:0]     magnitude
);
   import idf_pkg::*;

   logic [MAG_W-1:0] mag_ff, mag_in;

   assign mag_in = MAG_W'(square_x) + MAG_W'(square_y) + MAG_W'(square_z);

   always_ff @(posedge clock) begin
      if (advance) begin
         mag_ff <= mag_in;
      end
   end

   assign magnitude = mag_ff;
endmodule

FILE: src/idf_window.sv
// Window stage: magnitude ring, running total, frame/heartbeat decision, result register.
module idf_window #(
   parameter int WINDOW_LEN = idf_pkg::WINDOW_LEN_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  idf_pkg::pipe_ctrl_type        ctrl,
   input  logic [idf_pkg::MAG_W-1:0]     magnitude,
   input  logic [idf_pkg::TIME_W-1:0]    now_ms,
   input  idf_pkg::csr_type              csr,
   output logic                          out_valid,
   output idf_pkg::result_type           result
);
   import idf_pkg::*;

   localparam int PTR_W = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(WINDOW_LEN - 1);

   logic [MAG_W-1:0]   ring_ff [WINDOW_LEN];
   logic [PTR_W-1:0]   ptr_ff, ptr_in;
   logic [TOTAL_W-1:0] total_ff, total_in;
   logic [TIME_W-1:0]  last_frame_ff, last_frame_in;
   logic [TIME_W-1:0]  last_beat_ff, last_beat_in;
   logic               out_valid_ff;
   result_type         result_ff, result_in;

   logic [TIME_W-1:0]  frame_gap;
   logic [TIME_W-1:0]  beat_gap;
   logic               take;
   logic               coll;
   logic               beat;

   assign take      = ctrl.advance && ctrl.valid;
   assign total_in  = total_ff - TOTAL_W'(ring_ff[ptr_ff]) + TOTAL_W'(magnitude);
   assign ptr_in    = (ptr_ff == PTR_LAST) ? '0 : ptr_ff + 1'b1;
   assign frame_gap = now_ms - last_frame_ff;
   assign beat_gap  = now_ms - last_beat_ff;

   assign coll = (frame_gap > csr.min_data_gap_ms) && (total_in > csr.detect_threshold);
   // a frame sent this step restarts the data gap, which blocks the heartbeat
   assign beat = !coll && (beat_gap > csr.heartbeat_gap_ms)
                 && (frame_gap > csr.min_data_gap_ms);

   assign last_frame_in = coll ? now_ms : last_frame_ff;
   assign last_beat_in  = beat ? now_ms : last_beat_ff;

   always_comb begin
      result_in                 = '0;
      result_in.collision_send  = coll;
      result_in.heartbeat_send  = beat;
      result_in.window_total    = total_in[OUT_TOTAL_W-1:0];
      if (coll) begin
         result_in.frame_id        = csr.node_id;
         result_in.frame_magnitude = magnitude;
         result_in.frame_check     = frame_check_of(csr.node_id, magnitude);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < WINDOW_LEN; i++) begin
            ring_ff[i] <= '0;
         end
         ptr_ff        <= '0;
         total_ff      <= '0;
         last_frame_ff <= '0;
         last_beat_ff  <= '0;
         out_valid_ff  <= 1'b0;
      end else begin
         if (ctrl.advance) begin
            out_valid_ff <= ctrl.valid;
         end
         if (take) begin
            ring_ff[ptr_ff] <= magnitude;
            ptr_ff          <= ptr_in;
            total_ff        <= total_in;
            last_frame_ff   <= last_frame_in;
            last_beat_ff    <= last_beat_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         result_ff <= result_in;
      end
   end

   assign out_valid = out_valid_ff;
   assign result    = result_ff;
endmodule

FILE: src/impact_detect_and_frame.sv
// Top level: three axis lanes, magnitude merge and window/decision stage.
//
//  channel   direction  handshake     payload
//  req_chan  in         valid/ready   accel_x, accel_y, accel_z, now_ms
//  rsp_chan  out        valid/ready   collision_send, heartbeat_send, frame_id,
//                                     frame_magnitude, frame_check, window_total
//  csr_*     in         write enable  index 0..3, 32-bit data
//
// One sample per cycle while the response is not stalled; four register stages
// (divide, square, sum, window/decision), which each sample passes in that order.
// The whole pipeline moves as one: it advances whenever the result register is
// empty or being taken, so a stalled response holds every stage in place.
// Reset (synchronous) empties the pipeline, zeroes the ring, total and timestamps
// and loads the register defaults.
module impact_detect_and_frame #(
   parameter int WINDOW_LEN = idf_pkg::WINDOW_LEN_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   idf_req_if.sink                           req_chan,
   idf_rsp_if.source                         rsp_chan,
   input  logic                              csr_wr_en,
   input  logic [idf_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [idf_pkg::CSR_DATA_W-1:0]    csr_wr_data
);
   import idf_pkg::*;

   csr_type            csr_ff;
   logic               advance;
   logic               s1_valid_ff, s2_valid_ff, s3_valid_ff;
   logic [TIME_W-1:0]  s1_now_ff, s2_now_ff, s3_now_ff;
   logic [SQUARE_W-1:0] sq_x, sq_y, sq_z;
   logic [MAG_W-1:0]   magnitude;
   pipe_ctrl_type      win_ctrl;
   logic               out_valid;
   result_type         result;

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff.detect_threshold <= '0;
         csr_ff.min_data_gap_ms  <= MIN_DATA_GAP_RESET;
         csr_ff.heartbeat_gap_ms <= HEARTBEAT_GAP_RESET;
         csr_ff.node_id          <= '0;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_DETECT_THRESHOLD: csr_ff.detect_threshold <= csr_wr_data;
            CSR_MIN_DATA_GAP:     csr_ff.min_data_gap_ms  <= csr_wr_data;
            CSR_HEARTBEAT_GAP:    csr_ff.heartbeat_gap_ms <= csr_wr_data;
            CSR_NODE_ID:          csr_ff.node_id          <= csr_wr_data[ID_W-1:0];
            default: ;
         endcase
      end
   end

   assign advance        = !out_valid || rsp_chan.ready;
   assign req_chan.ready = advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= req_chan.valid;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_now_ff <= req_chan.now_ms;
         s2_now_ff <= s1_now_ff;
         s3_now_ff <= s2_now_ff;
      end
   end

   idf_lane u_lane_x (.clock(clock), .advance(advance), .accel(req_chan.accel_x),
                      .square(sq_x));
   idf_lane u_lane_y (.clock(clock), .advance(advance), .accel(req_chan.accel_y),
                      .square(sq_y));
   idf_lane u_lane_z (.clock(clock), .advance(advance), .accel(req_chan.accel_z),
                      .square(sq_z));

   idf_merge u_merge (
      .clock     (clock),
      .advance   (advance),
      .square_x  (sq_x),
      .square_y  (sq_y),
      .square_z  (sq_z),
      .magnitude (magnitude)
   );

   assign win_ctrl.advance = advance;
   assign win_ctrl.valid   = s3_valid_ff;

   idf_window #(.WINDOW_LEN(WINDOW_LEN)) u_window (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (win_ctrl),
      .magnitude (magnitude),
      .now_ms    (s3_now_ff),
      .csr       (csr_ff),
      .out_valid (out_valid),
      .result    (result)
   );

   assign rsp_chan.valid           = out_valid;
   assign rsp_chan.collision_send  = result.collision_send;
   assign rsp_chan.heartbeat_send  = result.heartbeat_send;
   assign rsp_chan.frame_id        = result.frame_id;
   assign rsp_chan.frame_magnitude = result.frame_magnitude;
   assign rsp_chan.frame_check     = result.frame_check;
   assign rsp_chan.window_total    = result.window_total;

   // a frame restarts the data gap, so both flags never rise together
   a_flags_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> !(rsp_chan.collision_send && rsp_chan.heartbeat_send))
      else $error("collision and heartbeat flagged in one transaction");

   a_frame_fields_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && !rsp_chan.collision_send) |->
         (rsp_chan.frame_id == '0 && rsp_chan.frame_magnitude == '0
          && rsp_chan.frame_check == '0))
      else $error("frame fields not cleared without a collision");

   a_last_stage_delivers: assert property (@(posedge clock) disable iff (reset)
      (s3_valid_ff && advance) |=> rsp_chan.valid)
      else $error("sample in last pipeline stage produced no response");

   a_stall_holds_pipe: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && !rsp_chan.ready) |=> $stable(s3_valid_ff) && $stable(s3_now_ff))
      else $error("pipeline moved while response stalled");
endmodule
